### hdl/quad_point_locate_normal_unit_assert.svh
// Assertion macros used by the port checker of the quad point locator.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef QUAD_POINT_LOCATE_NORMAL_UNIT_ASSERT_SVH
`define QUAD_POINT_LOCATE_NORMAL_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define QPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qpl_pkg.sv
// Package of the quad point locator: widths, codes and item types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package qpl_pkg;

  localparam int COORD_BITS       = 16;
  localparam int POINT_FRAC_BITS  = 4;
  localparam int NORMAL_FRAC_BITS = 8;

  localparam int CORNER_W = 48;
  localparam int SLOT_W   = 16;
  localparam int POINT_W  = 20;
  localparam int OUT_W    = 16;
  localparam int HIT_W    = 2;

  // Normal length scale; 127*127 = 16129 = 2^14 - 2^8 + 1
  localparam int NORM_GAIN   = 127;
  localparam int GAIN_SQ_HI  = 14;
  localparam int GAIN_SQ_LO  = 8;

  localparam logic [HIT_W-1:0] HIT_NONE   = 2'd0;
  localparam logic [HIT_W-1:0] HIT_FIRST  = 2'd1;
  localparam logic [HIT_W-1:0] HIT_SECOND = 2'd2;

  // Edge test widths (point format)
  localparam int SX_W = COORD_BITS + POINT_FRAC_BITS;
  localparam int PT_W = (SX_W > POINT_W) ? SX_W : POINT_W;
  localparam int ED_W = PT_W + 1;
  localparam int EP_W = 2 * ED_W;
  localparam int EF_W = EP_W + 1;

  // Normal widths
  localparam int ND_W  = COORD_BITS + 1;
  localparam int NP_W  = 2 * ND_W;
  localparam int NV_W  = NP_W + 1;
  localparam int MAG_W = NV_W - 1;
  localparam int SQ_W  = 2 * MAG_W;

  // Scale search widths
  localparam int K_VAL = NORM_GAIN << NORMAL_FRAC_BITS;
  localparam int Q_W   = $clog2(K_VAL + 1);
  localparam int R_W   = SQ_W + 2 * Q_W + 4;
  localparam int F_W   = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W;
  localparam int BK_LAST = Q_W + 1;

  // Edge list of both triangles: 0-1, 1-2, 2-0, 0-2, 2-3, 3-0 (entry 0 at LSB)
  localparam int NUM_EDGES = 6;
  localparam logic [2*NUM_EDGES-1:0] EDGE_A = {2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam logic [2*NUM_EDGES-1:0] EDGE_B = {2'd0, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1};

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [CORNER_W-1:0]       corner_zero;
    logic [CORNER_W-1:0]       corner_one;
    logic [CORNER_W-1:0]       corner_two;
    logic [CORNER_W-1:0]       corner_three;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [HIT_W-1:0]        hit_triangle;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
  } out_t;

  typedef struct packed {
    logic [HIT_W-1:0]       hit;
    logic signed [NV_W-1:0] nx;
    logic signed [NV_W-1:0] ny;
    logic signed [NV_W-1:0] nz;
  } mid_t;

endpackage

`default_nettype wire

### hdl/qpl_front.sv
// Front of the quad point locator: edge tests and raw face normals.
// Two stages; picks the hit triangle and its unscaled normal. Uses qpl_pkg.
`default_nettype none

module qpl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire qpl_pkg::in_t  in_item,
  input  wire logic          mq_full,
  output logic               mq_push,
  output qpl_pkg::mid_t      mq_data
);

  logic f_en;
  logic v1_r, v2_r;
  logic signed [qpl_pkg::EP_W-1:0] ea_r [qpl_pkg::NUM_EDGES];
  logic signed [qpl_pkg::EP_W-1:0] eb_r [qpl_pkg::NUM_EDGES];
  logic signed [qpl_pkg::EP_W-1:0] ea_nxt [qpl_pkg::NUM_EDGES];
  logic signed [qpl_pkg::EP_W-1:0] eb_nxt [qpl_pkg::NUM_EDGES];
  logic signed [qpl_pkg::NP_W-1:0] npa_r [6];
  logic signed [qpl_pkg::NP_W-1:0] npb_r [6];
  logic signed [qpl_pkg::NP_W-1:0] npa_nxt [6];
  logic signed [qpl_pkg::NP_W-1:0] npb_nxt [6];
  qpl_pkg::mid_t mid_r, mid_nxt;

  assign f_en    = !v2_r || !mq_full;
  assign in_full = !f_en;
  assign mq_push = v2_r && !mq_full;
  assign mq_data = mid_r;

  // Stage 1: unpack, differences and products
  always_comb begin
    logic [qpl_pkg::CORNER_W-1:0] cw [4];
    logic signed [qpl_pkg::COORD_BITS-1:0] vx [4];
    logic signed [qpl_pkg::COORD_BITS-1:0] vy [4];
    logic signed [qpl_pkg::COORD_BITS-1:0] vz [4];
    logic signed [qpl_pkg::PT_W-1:0] sx [4];
    logic signed [qpl_pkg::PT_W-1:0] sz [4];
    logic signed [qpl_pkg::PT_W-1:0] px, pz;
    logic signed [qpl_pkg::ED_W-1:0] d1, d2, d3, d4;
    logic signed [qpl_pkg::ND_W-1:0] dxab, dyab, dzab, dxbc, dybc, dzbc;
    logic [1:0] ia, ib;
    cw[0] = in_item.corner_zero;
    cw[1] = in_item.corner_one;
    cw[2] = in_item.corner_two;
    cw[3] = in_item.corner_three;
    for (int i = 0; i < 4; i++) begin
      vx[i] = cw[i][qpl_pkg::COORD_BITS-1:0];
      vy[i] = cw[i][qpl_pkg::SLOT_W+qpl_pkg::COORD_BITS-1:qpl_pkg::SLOT_W];
      vz[i] = cw[i][2*qpl_pkg::SLOT_W+qpl_pkg::COORD_BITS-1:2*qpl_pkg::SLOT_W];
      sx[i] = qpl_pkg::PT_W'(vx[i]) <<< qpl_pkg::POINT_FRAC_BITS;
      sz[i] = qpl_pkg::PT_W'(vz[i]) <<< qpl_pkg::POINT_FRAC_BITS;
    end
    px = qpl_pkg::PT_W'(in_item.point_x);
    pz = qpl_pkg::PT_W'(in_item.point_z);
    for (int e = 0; e < qpl_pkg::NUM_EDGES; e++) begin
      ia = qpl_pkg::EDGE_A[2*e +: 2];
      ib = qpl_pkg::EDGE_B[2*e +: 2];
      d1 = qpl_pkg::ED_W'(sz[ib]) - qpl_pkg::ED_W'(sz[ia]);
      d2 = qpl_pkg::ED_W'(px) - qpl_pkg::ED_W'(sx[ib]);
      d3 = qpl_pkg::ED_W'(sx[ib]) - qpl_pkg::ED_W'(sx[ia]);
      d4 = qpl_pkg::ED_W'(pz) - qpl_pkg::ED_W'(sz[ib]);
      ea_nxt[e] = d1 * d2;
      eb_nxt[e] = d3 * d4;
    end
    // triangle t uses corners 0, t+1, t+2
    for (int t = 0; t < 2; t++) begin
      dxab = qpl_pkg::ND_W'(vx[t+1]) - qpl_pkg::ND_W'(vx[0]);
      dyab = qpl_pkg::ND_W'(vy[t+1]) - qpl_pkg::ND_W'(vy[0]);
      dzab = qpl_pkg::ND_W'(vz[t+1]) - qpl_pkg::ND_W'(vz[0]);
      dxbc = qpl_pkg::ND_W'(vx[t+2]) - qpl_pkg::ND_W'(vx[t+1]);
      dybc = qpl_pkg::ND_W'(vy[t+2]) - qpl_pkg::ND_W'(vy[t+1]);
      dzbc = qpl_pkg::ND_W'(vz[t+2]) - qpl_pkg::ND_W'(vz[t+1]);
      npa_nxt[3*t]   = dyab * dzbc;
      npb_nxt[3*t]   = dzab * dybc;
      npa_nxt[3*t+1] = dzab * dxbc;
      npb_nxt[3*t+1] = dxab * dzbc;
      npa_nxt[3*t+2] = dxab * dybc;
      npb_nxt[3*t+2] = dyab * dxbc;
    end
  end

  // Stage 2: edge signs, normal components, triangle choice
  always_comb begin
    logic signed [qpl_pkg::EF_W-1:0] ef [qpl_pkg::NUM_EDGES];
    logic signed [qpl_pkg::NV_W-1:0] nv [6];
    logic in0, in1, nz0, nz1;
    for (int e = 0; e < qpl_pkg::NUM_EDGES; e++) begin
      ef[e] = qpl_pkg::EF_W'(ea_r[e]) - qpl_pkg::EF_W'(eb_r[e]);
    end
    for (int k = 0; k < 6; k++) begin
      nv[k] = qpl_pkg::NV_W'(npa_r[k]) - qpl_pkg::NV_W'(npb_r[k]);
    end
    in0 = !ef[0][qpl_pkg::EF_W-1] && !ef[1][qpl_pkg::EF_W-1] && !ef[2][qpl_pkg::EF_W-1];
    in1 = !ef[3][qpl_pkg::EF_W-1] && !ef[4][qpl_pkg::EF_W-1] && !ef[5][qpl_pkg::EF_W-1];
    nz0 = (nv[0] != '0) || (nv[1] != '0) || (nv[2] != '0);
    nz1 = (nv[3] != '0) || (nv[4] != '0) || (nv[5] != '0);
    mid_nxt = '0;
    priority if (in0 && nz0) begin
      mid_nxt.hit = qpl_pkg::HIT_FIRST;
      mid_nxt.nx  = nv[0];
      mid_nxt.ny  = nv[1];
      mid_nxt.nz  = nv[2];
    end else if (in1 && nz1) begin
      mid_nxt.hit = qpl_pkg::HIT_SECOND;
      mid_nxt.nx  = nv[3];
      mid_nxt.ny  = nv[4];
      mid_nxt.nz  = nv[5];
    end else begin
      mid_nxt.hit = qpl_pkg::HIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (f_en) begin
      v1_r <= in_push;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      for (int e = 0; e < qpl_pkg::NUM_EDGES; e++) begin
        ea_r[e] <= ea_nxt[e];
        eb_r[e] <= eb_nxt[e];
      end
      for (int k = 0; k < 6; k++) begin
        npa_r[k] <= npa_nxt[k];
        npb_r[k] <= npb_nxt[k];
      end
      mid_r <= mid_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/qpl_mid_q.sv
// Short queue between the front and the back of the quad point locator.
// Holds classified items; uses qpl_pkg.
`default_nettype none

module qpl_mid_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire qpl_pkg::mid_t wr_data,
  output logic               full,
  input  wire logic          pop,
  output qpl_pkg::mid_t      rd_data,
  output logic               empty
);

  qpl_pkg::mid_t mem [qpl_pkg::MQ_DEPTH];
  logic [qpl_pkg::MQ_AW-1:0] wp_r, rp_r;
  logic [qpl_pkg::MQ_CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == qpl_pkg::MQ_CW'(qpl_pkg::MQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wr_data;
  end

endmodule

`default_nettype wire

### hdl/qpl_back.sv
// Back of the quad point locator: scales the normal to length 127.
// Squares, then one shift-subtract stage per result bit, then a result queue.
// Uses qpl_pkg.
`default_nettype none

module qpl_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mq_empty,
  input  wire qpl_pkg::mid_t mq_data,
  output logic               mq_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output qpl_pkg::out_t      out_item
);

  logic b_en;
  logic [qpl_pkg::BK_LAST:0] vld_r;
  logic [qpl_pkg::HIT_W-1:0] hit_r [qpl_pkg::BK_LAST+1];
  logic [2:0] neg_r [qpl_pkg::BK_LAST+1];
  logic [qpl_pkg::SQ_W-1:0] sq_r [3];
  logic [qpl_pkg::SQ_W-1:0] sq_nxt [3];
  logic [qpl_pkg::R_W-1:0] len2_r [1:qpl_pkg::BK_LAST];
  logic [qpl_pkg::R_W-1:0] len2_init;
  logic [qpl_pkg::R_W-1:0] r_r [1:qpl_pkg::BK_LAST][3];
  logic [qpl_pkg::R_W-1:0] s_r [1:qpl_pkg::BK_LAST][3];
  logic [qpl_pkg::Q_W-1:0] q_r [1:qpl_pkg::BK_LAST][3];
  logic [qpl_pkg::R_W-1:0] r_nxt [1:qpl_pkg::BK_LAST][3];
  logic [qpl_pkg::R_W-1:0] s_nxt [1:qpl_pkg::BK_LAST][3];
  logic [qpl_pkg::Q_W-1:0] q_nxt [1:qpl_pkg::BK_LAST][3];
  logic [2:0] neg0;

  qpl_pkg::out_t oq_mem [qpl_pkg::OQ_DEPTH];
  logic [qpl_pkg::OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [qpl_pkg::OQ_CW-1:0] oq_cnt_r;
  logic oq_full, oq_push, oq_pop;
  qpl_pkg::out_t res;

  assign oq_full   = (oq_cnt_r == qpl_pkg::OQ_CW'(qpl_pkg::OQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign b_en      = !vld_r[qpl_pkg::BK_LAST] || !oq_full;
  assign mq_pop    = b_en && !mq_empty;
  assign oq_push   = vld_r[qpl_pkg::BK_LAST] && b_en;
  assign oq_pop    = out_pop && !out_empty;
  assign out_item  = oq_mem[oq_rp_r];

  // Stage 0: magnitudes and squares
  always_comb begin
    logic signed [qpl_pkg::NV_W-1:0] n [3];
    logic [qpl_pkg::MAG_W-1:0] mag;
    n[0] = mq_data.nx;
    n[1] = mq_data.ny;
    n[2] = mq_data.nz;
    for (int k = 0; k < 3; k++) begin
      neg0[k]   = n[k][qpl_pkg::NV_W-1];
      mag       = qpl_pkg::MAG_W'(neg0[k] ? -n[k] : n[k]);
      sq_nxt[k] = mag * mag;
    end
  end

  // Stage 1 entry: squared length and residual start c^2 * 127^2 * 4^frac.
  // Then the restoring search, MSB first: keep r = c^2 K^2 - q^2 len2 and s = q len2
  always_comb begin
    logic [qpl_pkg::R_W-1:0] c2;
    logic [qpl_pkg::R_W-1:0] inc;
    logic take;
    len2_init = qpl_pkg::R_W'(sq_r[0]) + qpl_pkg::R_W'(sq_r[1]) + qpl_pkg::R_W'(sq_r[2]);
    for (int k = 0; k < 3; k++) begin
      c2 = qpl_pkg::R_W'(sq_r[k]);
      r_nxt[1][k] = ((c2 << qpl_pkg::GAIN_SQ_HI) - (c2 << qpl_pkg::GAIN_SQ_LO) + c2)
                    << (2 * qpl_pkg::NORMAL_FRAC_BITS);
      s_nxt[1][k] = '0;
      q_nxt[1][k] = '0;
    end
    for (int j = 1; j < qpl_pkg::BK_LAST; j++) begin
      for (int k = 0; k < 3; k++) begin
        inc = (s_r[j][k] << (qpl_pkg::Q_W - j + 1))
            + (len2_r[j] << (2 * (qpl_pkg::Q_W - j)));
        take = (inc <= r_r[j][k]);
        r_nxt[j+1][k] = take ? r_r[j][k] - inc : r_r[j][k];
        s_nxt[j+1][k] = take ? s_r[j][k] + (len2_r[j] << (qpl_pkg::Q_W - j)) : s_r[j][k];
        q_nxt[j+1][k] = q_r[j][k] | (qpl_pkg::Q_W'(take) << (qpl_pkg::Q_W - j));
      end
    end
  end

  // Result: apply signs, zero when nothing was hit
  always_comb begin
    logic [qpl_pkg::F_W-1:0] qf [3];
    logic [qpl_pkg::OUT_W-1:0] cv [3];
    for (int k = 0; k < 3; k++) begin
      qf[k] = qpl_pkg::F_W'(q_r[qpl_pkg::BK_LAST][k]);
      qf[k] = neg_r[qpl_pkg::BK_LAST][k] ? -qf[k] : qf[k];
      cv[k] = (hit_r[qpl_pkg::BK_LAST] != qpl_pkg::HIT_NONE) ? qf[k][qpl_pkg::OUT_W-1:0] : '0;
    end
    res.hit_triangle = hit_r[qpl_pkg::BK_LAST];
    res.normal_x     = cv[0];
    res.normal_y     = cv[1];
    res.normal_z     = cv[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (b_en) begin
      vld_r <= {vld_r[qpl_pkg::BK_LAST-1:0], !mq_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      hit_r[0] <= mq_data.hit;
      neg_r[0] <= neg0;
      for (int k = 0; k < 3; k++) sq_r[k] <= sq_nxt[k];
      len2_r[1] <= len2_init;
      for (int j = 2; j <= qpl_pkg::BK_LAST; j++) begin
        len2_r[j] <= len2_r[j-1];
      end
      for (int j = 1; j <= qpl_pkg::BK_LAST; j++) begin
        hit_r[j] <= hit_r[j-1];
        neg_r[j] <= neg_r[j-1];
        for (int k = 0; k < 3; k++) begin
          r_r[j][k] <= r_nxt[j][k];
          s_r[j][k] <= s_nxt[j][k];
          q_r[j][k] <= q_nxt[j][k];
        end
      end
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wp_r <= oq_wp_r + 1'b1;
      if (oq_pop)  oq_rp_r <= oq_rp_r + 1'b1;
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_mem[oq_wp_r] <= res;
  end

endmodule

`default_nettype wire

### hdl/quad_point_locate_normal_unit.sv
// Quad point locator with unit face normal: takes one quad and point per cycle
// while the input does not report full, and returns one item per quad, in order.
// Path: two front stages (edge tests, normals), the middle queue, a squaring
// stage, a setup stage and one shift-subtract stage per normal bit (15 at 8
// fraction bits), then the result queue. The shift-subtract chain sets the
// latency; every stage is pipelined, so the sustained rate is one item per cycle
// while the result queue does not fill. A full result queue stalls the back
// only; the middle queue absorbs the front until it fills, and then the input
// reports full. Uses qpl_pkg, qpl_front, qpl_mid_q and qpl_back.
`default_nettype none

module quad_point_locate_normal_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire qpl_pkg::in_t  in_item,
  output logic               out_empty,
  input  wire logic          out_pop,
  output qpl_pkg::out_t      out_item
);

  logic mq_push, mq_full, mq_pop, mq_empty;
  qpl_pkg::mid_t mq_wdata, mq_rdata;

  qpl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .mq_full (mq_full),
    .mq_push (mq_push),
    .mq_data (mq_wdata)
  );

  qpl_mid_q u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mq_push),
    .wr_data (mq_wdata),
    .full    (mq_full),
    .pop     (mq_pop),
    .rd_data (mq_rdata),
    .empty   (mq_empty)
  );

  qpl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_empty  (mq_empty),
    .mq_data   (mq_rdata),
    .mq_pop    (mq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### hdl/qpl_checker.sv
// Port checker for the quad point locator, bound to the top level.
// Uses qpl_pkg and the assertion macros header.
`default_nettype none

`include "quad_point_locate_normal_unit_assert.svh"

module qpl_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_empty,
  input wire logic          out_pop,
  input wire qpl_pkg::out_t out_item
);

  logic is_miss, nrm_zero;

  assign is_miss  = (out_item.hit_triangle == qpl_pkg::HIT_NONE);
  assign nrm_zero = (out_item.normal_x == '0) && (out_item.normal_y == '0) &&
                    (out_item.normal_z == '0);

  `QPL_ASSERT_IMP(a_hit_code, !out_empty, out_item.hit_triangle <= qpl_pkg::HIT_SECOND, "bad hit code")
  `QPL_ASSERT_IMP(a_miss_zero, !out_empty && is_miss, nrm_zero, "miss with nonzero normal")
  `QPL_ASSERT_NXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_item), "result changed")
  `QPL_ASSERT_IMP(a_reset_empty, $rose(rst_n), out_empty, "result after reset")

endmodule

bind quad_point_locate_normal_unit qpl_checker u_qpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

`default_nettype wire

### tb/tb_top.sv
// Testbench of quad_point_locate_normal_unit: directed quads, then random quads,
// each result checked against an in-bench predictor. Depends on qpl_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam int N_RANDOM = 1830;
  localparam longint K_SCALE = 127 << qpl_pkg::NORMAL_FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  qpl_pkg::in_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  qpl_pkg::out_t out_item;

  qpl_pkg::out_t expected_q[$];
  int fail_count = 0;
  bit stim_done = 0;
  bit hold_off = 0;
  bit calm = 0;

  quad_point_locate_normal_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always #10 clk = ~clk;

  function automatic longint coord(logic [qpl_pkg::CORNER_W-1:0] w, int slot);
    logic [qpl_pkg::SLOT_W-1:0] s;
    logic signed [qpl_pkg::COORD_BITS-1:0] c;
    s = w[slot*qpl_pkg::SLOT_W +: qpl_pkg::SLOT_W];
    c = s[qpl_pkg::COORD_BITS-1:0];
    return longint'(c);
  endfunction

  function automatic longint edge_fn(longint ax, longint az, longint bx, longint bz,
                                     longint px, longint pz);
    return (bz - az) * (px - bx) - (bx - ax) * (pz - bz);
  endfunction

  // largest q with q^2 * len2 <= c^2 * k^2, sign of c, low 16 bits
  function automatic logic [qpl_pkg::OUT_W-1:0] scale_comp(longint c, logic [127:0] len2);
    logic [127:0] mc, rhs, lhs;
    longint lo, hi, mid, q;
    mc = (c < 0) ? -c : c;
    rhs = mc * mc * K_SCALE * K_SCALE;
    lo = 0;
    hi = K_SCALE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = len2 * mid * mid;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    q = (c < 0) ? -lo : lo;
    return q[qpl_pkg::OUT_W-1:0];
  endfunction

  function automatic qpl_pkg::out_t locate_normal(qpl_pkg::in_t it);
    longint vx[4], vy[4], vz[4], sx[4], sz[4];
    longint px, pz, nx, ny, nz;
    int a, b, c;
    logic [127:0] len2, mx, my, mz;
    logic [qpl_pkg::CORNER_W-1:0] cw[4];
    qpl_pkg::out_t r;
    r = '0;
    cw[0] = it.corner_zero; cw[1] = it.corner_one;
    cw[2] = it.corner_two; cw[3] = it.corner_three;
    px = longint'(it.point_x);
    pz = longint'(it.point_z);
    for (int i = 0; i < 4; i++) begin
      vx[i] = coord(cw[i], 0); vy[i] = coord(cw[i], 1); vz[i] = coord(cw[i], 2);
      sx[i] = vx[i] <<< qpl_pkg::POINT_FRAC_BITS;
      sz[i] = vz[i] <<< qpl_pkg::POINT_FRAC_BITS;
    end
    for (int t = 0; t < 2; t++) begin
      a = 0; b = t + 1; c = t + 2;
      if (edge_fn(sx[a], sz[a], sx[b], sz[b], px, pz) < 0) continue;
      if (edge_fn(sx[b], sz[b], sx[c], sz[c], px, pz) < 0) continue;
      if (edge_fn(sx[c], sz[c], sx[a], sz[a], px, pz) < 0) continue;
      nx = (vy[b]-vy[a])*(vz[c]-vz[b]) - (vz[b]-vz[a])*(vy[c]-vy[b]);
      ny = (vz[b]-vz[a])*(vx[c]-vx[b]) - (vx[b]-vx[a])*(vz[c]-vz[b]);
      nz = (vx[b]-vx[a])*(vy[c]-vy[b]) - (vy[b]-vy[a])*(vx[c]-vx[b]);
      if (nx == 0 && ny == 0 && nz == 0) continue;
      // squares need more than 64 bits
      mx = (nx < 0) ? -nx : nx;
      my = (ny < 0) ? -ny : ny;
      mz = (nz < 0) ? -nz : nz;
      len2 = mx * mx + my * my + mz * mz;
      r.hit_triangle = (t == 0) ? qpl_pkg::HIT_FIRST : qpl_pkg::HIT_SECOND;
      r.normal_x = scale_comp(nx, len2);
      r.normal_y = scale_comp(ny, len2);
      r.normal_z = scale_comp(nz, len2);
      break;
    end
    return r;
  endfunction

  function automatic logic [qpl_pkg::CORNER_W-1:0] vtx(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [qpl_pkg::CORNER_W-1:0] rand_vtx(bit narrow);
    if (narrow)
      return vtx($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                 $urandom_range(0, 200) - 100);
    return qpl_pkg::CORNER_W'({$urandom(), $urandom()});
  endfunction

  // point inside the xz box of the quad, mostly
  function automatic qpl_pkg::in_t rand_quad();
    qpl_pkg::in_t it;
    int sel;
    bit narrow;
    sel = $urandom_range(0, 9);
    narrow = (sel < 7);
    it.corner_zero = rand_vtx(narrow);
    it.corner_one = rand_vtx(narrow);
    it.corner_two = rand_vtx(narrow);
    it.corner_three = rand_vtx(narrow);
    if (sel < 7) begin
      it.point_x = qpl_pkg::POINT_W'(($urandom_range(0, 200) - 100) * 16
                                     + $urandom_range(0, 15));
      it.point_z = qpl_pkg::POINT_W'(($urandom_range(0, 200) - 100) * 16
                                     + $urandom_range(0, 15));
    end else if (sel < 9) begin
      // well-formed counterclockwise-in-xz quad around the point
      it.corner_zero = vtx(-1000, $urandom_range(0, 2000) - 1000, -1000);
      it.corner_one = vtx(-1000, $urandom_range(0, 2000) - 1000, 1000);
      it.corner_two = vtx(1000, $urandom_range(0, 2000) - 1000, 1000);
      it.corner_three = vtx(1000, $urandom_range(0, 2000) - 1000, -1000);
      if ($urandom_range(0, 1)) begin
        it.corner_one = {it.corner_one[47:32], it.corner_one[31:16], it.corner_zero[15:0]};
        it.corner_three = {it.corner_zero[47:32], it.corner_three[31:0]};
      end
      it.point_x = qpl_pkg::POINT_W'($urandom_range(0, 32000) - 16000);
      it.point_z = qpl_pkg::POINT_W'($urandom_range(0, 32000) - 16000);
    end else begin
      it.point_x = qpl_pkg::POINT_W'($urandom());
      it.point_z = qpl_pkg::POINT_W'($urandom());
    end
    return it;
  endfunction

  // hold push high from item to item; drop it only while idling
  task automatic send_quad(qpl_pkg::in_t it);
    while ($urandom_range(0, 99) < 34 && !calm) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_q.push_back(locate_normal(it));
  endtask

  typedef struct {
    qpl_pkg::in_t it;
    bit known;
    qpl_pkg::out_t res;
  } vec_t;

  initial begin
    vec_t dir[$];
    vec_t v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // all zero: degenerate, no hit
    v.it = '0; v.known = 1; v.res = '0; dir.push_back(v);
    // flat square in xz at y=0, one point in each triangle: normal straight up
    v.it.corner_zero = vtx(0, 0, 0); v.it.corner_one = vtx(0, 0, 10);
    v.it.corner_two = vtx(10, 0, 10); v.it.corner_three = vtx(10, 0, 0);
    v.known = 0;
    v.it.point_x = 20'sd80; v.it.point_z = 20'sd16; dir.push_back(v);
    v.it.point_x = 20'sd16; v.it.point_z = 20'sd80; dir.push_back(v);
    // on the shared diagonal and on a corner
    v.it.point_x = 20'sd80; v.it.point_z = 20'sd80; dir.push_back(v);
    v.it.point_x = 20'sd0; v.it.point_z = 20'sd0; dir.push_back(v);
    // outside: known no hit
    v.it.point_x = -20'sd1; v.it.point_z = 20'sd5; v.known = 1; v.res = '0; dir.push_back(v);
    v.it.point_x = 20'h7FFFF; v.it.point_z = 20'h80000; dir.push_back(v);
    v.it.point_x = 20'h80000; v.it.point_z = 20'h7FFFF; dir.push_back(v);
    // first triangle degenerate in xz and collinear: second one hits
    v.known = 0;
    v.it.corner_one = vtx(0, 0, 0);
    v.it.point_x = 20'sd100; v.it.point_z = 20'sd20; dir.push_back(v);
    // tilted, extreme coordinates
    v.it.corner_zero = vtx(-32768, -32768, -32768);
    v.it.corner_one = vtx(-32768, 32767, 32767);
    v.it.corner_two = vtx(32767, -32768, 32767);
    v.it.corner_three = vtx(32767, 32767, -32768);
    v.it.point_x = 20'sd0; v.it.point_z = 20'sd0; dir.push_back(v);
    v.it.point_x = 20'sd16; v.it.point_z = -20'sd160; dir.push_back(v);
    v.it.corner_zero = '1; v.it.corner_one = {48{1'b1}} ^ 48'h1;
    v.it.corner_two = 48'h7FFF_7FFF_7FFF; v.it.point_x = '1; v.it.point_z = '1;
    dir.push_back(v);
    // vertical faces: normal in x only
    v.it.corner_zero = vtx(0, 0, 0); v.it.corner_one = vtx(0, 5, 0);
    v.it.corner_two = vtx(0, 5, 9); v.it.corner_three = vtx(0, 0, 9);
    v.it.point_x = 20'sd0; v.it.point_z = 20'sd32; dir.push_back(v);
    foreach (dir[i]) begin
      send_quad(dir[i].it);
      if (dir[i].known) expected_q[$] = dir[i].res;
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 900);
      if (n == 1000) hold_off = 1;
      if (n == 1040) hold_off = 0;
      send_quad(rand_quad());
    end
    in_push <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls, one long hold-off while the sender fills the block
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_pop <= 1'b0;
        for (gap = 0; gap < 60; gap++) @(posedge clk);
      end
      out_pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    qpl_pkg::out_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_item);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.hit_triangle !== e.hit_triangle) begin
          $error("hit_triangle exp %0d got %0d", e.hit_triangle, out_item.hit_triangle);
          fail_count++;
        end
        if (out_item.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, out_item.normal_x);
          fail_count++;
        end
        if (out_item.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, out_item.normal_y);
          fail_count++;
        end
        if (out_item.normal_z !== e.normal_z) begin
          $error("normal_z exp %0d got %0d", e.normal_z, out_item.normal_z);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!out_empty) begin
      $error("extra result left in the block");
      fail_count++;
    end
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+hdl
hdl/qpl_pkg.sv
hdl/qpl_front.sv
hdl/qpl_mid_q.sv
hdl/qpl_back.sv
hdl/quad_point_locate_normal_unit.sv
hdl/qpl_checker.sv
tb/tb_top.sv
